@@ rtl/rce_pkg.sv @@
// shared types, constants and digit helpers for the radix conversion digit emitter
package rce_pkg;

    localparam int VALUE_W     = 31;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_ALPHA   = CHAR_W'(55);

    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   dividend;
        logic [RADIX_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quot;
        logic [DIGIT_W-1:0]   rem;
    } t_div_rsp;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
        logic [RADIX_W-1:0] r;
        if (v < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            r = RADIX_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_W'(CHAR_ZERO + CHAR_W'(d));
        end else begin
            c = CHAR_W'(CHAR_ALPHA + CHAR_W'(d));
        end
        return c;
    endfunction

endpackage

@@ rtl/rce_if.sv @@
// valid/ready channel interfaces for configuration, input and digit output
interface rce_cfg_if import rce_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

interface rce_in_if import rce_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rce_out_if import rce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

@@ rtl/rce_div.sv @@
// iterative divider by a small radix, eight quotient bits per cycle
module rce_div import rce_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int WORK_W  = 32;
    localparam int STEPS   = 8;
    localparam int CYCLES  = WORK_W / STEPS;
    localparam int CNT_W   = $clog2(CYCLES);

    logic [WORK_W-1:0]  r_work, n_work;
    logic [DIGIT_W-1:0] r_rem,  n_rem;
    logic [RADIX_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_comb begin
        logic [RADIX_W-1:0] part;
        logic [WORK_W-1:0]  w;
        logic [DIGIT_W-1:0] rm;
        w  = r_work;
        rm = r_rem;
        for (int k = 0; k < STEPS; k++) begin
            part = {rm, w[WORK_W-1]};
            w    = {w[WORK_W-2:0], 1'b0};
            if (part >= r_div) begin
                part = RADIX_W'(part - r_div);
                w[0] = 1'b1;
            end
            rm = part[DIGIT_W-1:0];
        end
        n_work = w;
        n_rem  = rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
                if (r_cnt == CNT_W'(CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= WORK_W'(i_req.dividend);
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work[VALUE_W-1:0];
    assign o_rsp.rem  = r_rem;

endmodule

@@ rtl/radix_conversion_digit_emitter.sv @@
// top level: integer to radix ascii conversion with digit stack and sequencer
// Each accepted value is divided repeatedly by the configured radix (2 to 16,
// written values outside that range are clamped) and its digits come out most
// significant first as upper-case ASCII, one beat per digit, with last_digit
// set on the least significant one; zero gives a single '0'. The input is not
// ready while a value is in work. Each division runs on one shared divider
// that settles eight quotient bits per cycle, and each digit goes onto the
// digit stack; popping it (a registered memory read) and showing it follow
// once all divisions are done, most significant digit first. The radix
// register can be written at any idle time.
module radix_conversion_digit_emitter import rce_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rce_cfg_if.sink   i_cfg,
    rce_in_if.sink    i_in,
    rce_out_if.source o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_RD   = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [SP_W-1:0]    r_sp, n_sp;
    logic [SP_W-1:0]    sp_dec;
    logic [RADIX_W-1:0] r_radix;
    logic [DIGIT_W-1:0] r_rd_data;
    logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];
    logic               in_acc;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign in_acc  = i_in.valid && i_in.ready;
    assign sp_dec  = SP_W'(r_sp - 1'b1);

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg.valid) begin
            r_radix <= clamp_radix(i_cfg.radix);
        end
    end

    rce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state          = r_state;
        n_sp             = r_sp;
        div_req.start    = 1'b0;
        div_req.dividend = (r_state == S_IDLE) ? i_in.value : div_rsp.quot;
        div_req.divisor  = r_radix;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    div_req.start = 1'b1;
                    n_sp          = '0;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_sp = SP_W'(r_sp + 1'b1);
                    if (div_rsp.quot == '0) begin
                        n_state = S_RD;
                    end else begin
                        div_req.start = 1'b1;
                    end
                end
            end
            S_RD: begin
                n_sp    = sp_dec;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    n_state = (r_sp == '0) ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
        end
    end

    // digit stack
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_rsp.done) begin
            stack_mem[r_sp[ADDR_W-1:0]] <= div_rsp.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rd_data <= stack_mem[sp_dec[ADDR_W-1:0]];
        end
    end

    assign o_out.valid      = (r_state == S_EMIT);
    assign o_out.digit_char = digit_glyph(r_rd_data);
    assign o_out.last_digit = (r_sp == '0);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("output beat shown while input is ready");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.last_digit |=> i_in.ready)
        else $error("input not ready after last digit beat");

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

endmodule
